[sv/rcfb_pkg.sv]
// Shared types, constants and helper functions for the robot command frame builder.
package rcfb_pkg;

  // Fixed frame layout constants
  localparam int MOTOR_FIELDS = 4;
  localparam int MSEL_W       = $clog2(MOTOR_FIELDS);

  localparam logic [7:0]  FRAME_ESC     = 8'h1B;
  localparam logic [7:0]  FRAME_TAB     = 8'h09;
  localparam logic [15:0] CHECK_MODULUS = 16'h4599;

  // Option byte dribble codes (bits 7..6)
  localparam logic [7:0] OPT_DRIB_POS  = 8'b1000_0000;
  localparam logic [7:0] OPT_DRIB_NEG  = 8'b1100_0000;
  localparam logic [7:0] OPT_SIGN_MASK = 8'b0011_1111;

  // Dribble mode input codes
  localparam logic [1:0] DRIBBLE_OFF = 2'd0;
  localparam logic [1:0] DRIBBLE_POS = 2'd1;
  localparam logic [1:0] DRIBBLE_NEG = 2'd2;

  // Classified command, as held in the queue
  typedef struct packed {
    logic [2:0]                   robot;
    logic [MOTOR_FIELDS-1:0][7:0] mag;
    logic [7:0]                   option;
    logic [7:0]                   sum;
  } desc_t;

  // Queue head as seen by the sequencer
  typedef struct packed {
    logic  valid;
    desc_t desc;
  } head_t;

  // Magnitude of a 9-bit two's complement value, saturated at 255
  function automatic logic [7:0] motor_mag(input logic [8:0] v);
    logic [8:0] m;
    m = v[8] ? (~v + 9'd1) : v;
    return m[8] ? 8'hFF : m[7:0];
  endfunction

  // Fold one byte into the running remainder: r = (r * 256 + data) mod CHECK_MODULUS,
  // one restoring step per bit
  function automatic logic [14:0] check_fold(input logic [14:0] rem, input logic [7:0] data);
    logic [15:0] t;
    logic [14:0] r;
    r = rem;
    for (int i = 7; i >= 0; i--) begin
      t = {r, data[i]};
      if (t >= CHECK_MODULUS) begin
        t = t - CHECK_MODULUS;
      end
      r = t[14:0];
    end
    return r;
  endfunction

endpackage

[sv/rcfb_if.sv]
// Valid/ready channel interfaces for commands in and frame bytes out.
interface rcfb_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        robot_number;
  logic signed [8:0] motor_0;
  logic signed [8:0] motor_1;
  logic signed [8:0] motor_2;
  logic signed [8:0] motor_3;
  logic [1:0]        dribble_mode;

  modport source (
    output valid, robot_number, motor_0, motor_1, motor_2, motor_3, dribble_mode,
    input  ready
  );
  modport sink (
    input  valid, robot_number, motor_0, motor_1, motor_2, motor_3, dribble_mode,
    output ready
  );
endinterface

interface rcfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (
    output valid, frame_byte, frame_end,
    input  ready
  );
  modport sink (
    input  valid, frame_byte, frame_end,
    output ready
  );
endinterface

[sv/rcfb_front.sv]
// Front end: accepts a command and classifies it into magnitudes, option byte and sum.
module rcfb_front #(
  parameter int MOTOR_COUNT = 4
) (
  rcfb_cmd_if.sink        cmd,
  input  logic            full,
  output logic            push,
  output rcfb_pkg::desc_t desc
);

  logic [rcfb_pkg::MOTOR_FIELDS-1:0][8:0] motors;

  assign motors = {cmd.motor_3, cmd.motor_2, cmd.motor_1, cmd.motor_0};

  // Accept whenever the queue has room
  assign cmd.ready = !full;
  assign push      = cmd.valid && !full;

  // Magnitudes, sign flags, dribble bits and byte sum
  always_comb begin
    logic [7:0] opt;
    logic [7:0] acc;
    opt = '0;
    desc.robot = cmd.robot_number;
    desc.mag   = '0;
    for (int m = 0; m < rcfb_pkg::MOTOR_FIELDS; m++) begin
      if (m < MOTOR_COUNT) begin
        desc.mag[m] = rcfb_pkg::motor_mag(motors[m]);
        opt[m]      = motors[m][8];
      end
    end
    opt = opt & rcfb_pkg::OPT_SIGN_MASK;
    case (cmd.dribble_mode)
      rcfb_pkg::DRIBBLE_POS: opt = opt | rcfb_pkg::OPT_DRIB_POS;
      rcfb_pkg::DRIBBLE_NEG: opt = opt | rcfb_pkg::OPT_DRIB_NEG;
      default:               opt = opt;
    endcase
    acc = {5'b0, cmd.robot_number} + opt;
    for (int m = 0; m < rcfb_pkg::MOTOR_FIELDS; m++) begin
      acc = acc + desc.mag[m];
    end
    desc.option = opt;
    desc.sum    = acc;
  end

endmodule

[sv/rcfb_queue.sv]
// Two-entry queue of classified commands between the front end and the byte sequencer.
module rcfb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rcfb_pkg::desc_t push_desc,
  input  logic            pop,
  output logic            full,
  output rcfb_pkg::head_t head
);

  rcfb_pkg::desc_t mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head.valid = (count_r != 2'd0);
  assign head.desc  = mem[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

endmodule

[sv/rcfb_back.sv]
// Back end: walks the frame one byte per transfer and folds the remainder check.
module rcfb_back #(
  parameter int MOTOR_COUNT = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  rcfb_pkg::head_t head,
  output logic            pop,
  rcfb_byte_if.source     out
);

  localparam int FRAME_LEN = 7 + MOTOR_COUNT;
  localparam int IDX_W     = $clog2(FRAME_LEN);

  localparam logic [IDX_W-1:0] POS_ESC    = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_ROBOT  = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_MOTOR  = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_OPT    = IDX_W'(2 + MOTOR_COUNT);
  localparam logic [IDX_W-1:0] POS_SUM    = IDX_W'(3 + MOTOR_COUNT);
  localparam logic [IDX_W-1:0] POS_CHK_HI = IDX_W'(4 + MOTOR_COUNT);
  localparam logic [IDX_W-1:0] POS_CHK_LO = IDX_W'(5 + MOTOR_COUNT);
  localparam logic [IDX_W-1:0] POS_TAB    = IDX_W'(6 + MOTOR_COUNT);

  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [14:0]                 rem_r, rem_nxt;
  logic [IDX_W-1:0]            motor_off;
  logic [rcfb_pkg::MSEL_W-1:0] motor_sel;
  logic [7:0]                  byte_val;
  logic                        fold_en;
  logic                        last;
  logic                        xfer;

  assign motor_off = idx_r - POS_MOTOR;
  assign motor_sel = motor_off[rcfb_pkg::MSEL_W-1:0];

  // Byte select for the current frame position
  always_comb begin
    fold_en  = 1'b0;
    byte_val = rcfb_pkg::FRAME_TAB;
    if (idx_r == POS_ESC) begin
      byte_val = rcfb_pkg::FRAME_ESC;
    end else if (idx_r == POS_ROBOT) begin
      byte_val = {5'b0, head.desc.robot};
      fold_en  = 1'b1;
    end else if (idx_r < POS_OPT) begin
      byte_val = head.desc.mag[motor_sel];
      fold_en  = 1'b1;
    end else if (idx_r == POS_OPT) begin
      byte_val = head.desc.option;
      fold_en  = 1'b1;
    end else if (idx_r == POS_SUM) begin
      byte_val = head.desc.sum;
      fold_en  = 1'b1;
    end else if (idx_r == POS_CHK_HI) begin
      byte_val = {1'b0, rem_r[14:8]};
    end else if (idx_r == POS_CHK_LO) begin
      byte_val = rem_r[7:0];
    end
  end

  assign last           = (idx_r == POS_TAB);
  assign out.valid      = head.valid;
  assign out.frame_byte = byte_val;
  assign out.frame_end  = last;
  assign xfer           = head.valid && out.ready;
  assign pop            = xfer && last;

  // Position counter and remainder update on each transfer
  always_comb begin
    idx_nxt = idx_r;
    rem_nxt = rem_r;
    if (xfer) begin
      idx_nxt = last ? POS_ESC : idx_r + IDX_W'(1);
      if (idx_r == POS_ESC) begin
        rem_nxt = '0;
      end else if (fold_en) begin
        rem_nxt = rcfb_pkg::check_fold(rem_r, byte_val);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= POS_ESC;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
  end

endmodule

[sv/robot_command_frame_builder_core.sv]
// Top level of the robot command frame builder: front end, command queue, byte sequencer.
//
//  channel   dir   handshake     payload
//  in_cmd    in    valid/ready   robot_number, motor_0..motor_3, dribble_mode
//  out_byte  out   valid/ready   frame_byte, frame_end
//
// Each command yields 7 + MOTOR_COUNT bytes (11 at the default), one per cycle while
// the output is ready; the byte sequencer emits one byte per transfer. The remainder
// check is folded over the robot, motor, option and sum bytes, one byte per transfer.
// A two-entry queue lets the next command be taken while a frame is being sent.
// Reset is synchronous, active low, and empties the queue and restarts the frame position.
// An output stall holds the current byte; input is refused only when the queue is full.
module robot_command_frame_builder_core #(
  parameter int MOTOR_COUNT = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  rcfb_cmd_if.sink     in_cmd,
  rcfb_byte_if.source  out_byte
);

  logic            push;
  logic            pop;
  logic            full;
  rcfb_pkg::desc_t push_desc;
  rcfb_pkg::head_t head;

  // Command classification
  rcfb_front #(.MOTOR_COUNT(MOTOR_COUNT)) u_front (
    .cmd  (in_cmd),
    .full (full),
    .push (push),
    .desc (push_desc)
  );

  // Command queue
  rcfb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .full      (full),
    .head      (head)
  );

  // Frame byte sequencer
  rcfb_back #(.MOTOR_COUNT(MOTOR_COUNT)) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (head),
    .pop   (pop),
    .out   (out_byte)
  );

endmodule
